// ===== src/bole_pkg.sv =====
// Shared types and constants of the bounded ordered list engine.
package bole_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int MAX_DEPTH     = 64;
   localparam int CTRL_W        = $clog2(MAX_DEPTH + 1);

   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;
   localparam int LEN_W    = 5;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 40;

   typedef enum logic [FUNC_W-1:0] {
      FN_INS_FRONT = 3'd0,
      FN_INS_BACK  = 3'd1,
      FN_INS_AT    = 3'd2,
      FN_DEL_FRONT = 3'd3,
      FN_DEL_BACK  = 3'd4,
      FN_DEL_AT    = 3'd5,
      FN_DEL_VALUE = 3'd6,
      FN_LIST      = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_BADPOS   = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_REMOVE_HIT,
      CELL_ROTATE,
      CELL_COMPARE
   } cell_kind_type;

   typedef struct packed {
      cell_kind_type        kind;
      logic [CTRL_W-1:0]    pos;
      logic [CTRL_W-1:0]    count;
      logic [VALUE_W-1:0]   operand;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_MATCH,
      SEQ_EXEC
   } seq_state_type;

endpackage

// ===== src/bole_cell.sv =====
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
module bole_cell #(
   parameter int IDX = 0
) (
   input  logic                             clock,
   input  bole_pkg::cell_ctrl_type          ctrl,
   input  logic [bole_pkg::VALUE_W-1:0]     left_value,
   input  logic [bole_pkg::VALUE_W-1:0]     right_value,
   input  logic [bole_pkg::VALUE_W-1:0]     head_value,
   input  logic                             hit_in,
   output logic [bole_pkg::VALUE_W-1:0]     value,
   output logic                             match
);
   import bole_pkg::*;

   localparam logic [CTRL_W-1:0] MY_IDX = CTRL_W'(IDX);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               match_ff;
   logic               match_in;

   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      case (ctrl.kind)
         CELL_INSERT: begin
            if (MY_IDX == ctrl.pos) begin
               value_in = ctrl.operand;
            end else if (MY_IDX > ctrl.pos) begin
               value_in = left_value;
            end
         end
         CELL_REMOVE: begin
            if (MY_IDX >= ctrl.pos) begin
               value_in = right_value;
            end
         end
         CELL_REMOVE_HIT: begin
            // Every cell at or after the first match pulls from its right neighbor.
            if (hit_in) begin
               value_in = right_value;
            end
         end
         CELL_ROTATE: begin
            // The front entry wraps around to the last occupied cell.
            if (MY_IDX == ctrl.pos) begin
               value_in = head_value;
            end else if (MY_IDX < ctrl.pos) begin
               value_in = right_value;
            end
         end
         CELL_COMPARE: begin
            match_in = (value_ff == ctrl.operand) && (MY_IDX < ctrl.count);
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

// ===== src/bole_seq.sv =====
// Sequencer of the list engine: operation decode, entry count, listing and result register.
module bole_seq #(
   parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bole_pkg::REQ_W-1:0]       req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bole_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                             rsp_tlast,
   input  logic [bole_pkg::VALUE_W-1:0]     head_value,
   input  logic                             any_hit,
   output bole_pkg::cell_ctrl_type          ctrl
);
   import bole_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CTRL_W-1:0] DEPTH_C = CTRL_W'(DEPTH);

   seq_state_type      state_ff, state_in;
   func_type           func_ff, func_in;
   logic [VALUE_W-1:0] operand_ff, operand_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      list_idx_ff, list_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_item_ff, rsp_item_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]   rsp_length_ff, rsp_length_in;

   logic [CTRL_W-1:0]  cnt_x;
   logic [CTRL_W-1:0]  pos_x;
   logic [CTRL_W-1:0]  idx_x;
   logic [CTRL_W-1:0]  ins_pos;
   logic [CTRL_W-1:0]  new_cnt;
   status_type         op_status;
   cell_kind_type      op_kind;
   logic [CTRL_W-1:0]  op_pos;
   logic [VALUE_W-1:0] op_item;
   logic               op_last;
   logic               slot_free;

   assign cnt_x = CTRL_W'(count_ff);
   assign pos_x = CTRL_W'(pos_ff);
   assign idx_x = CTRL_W'(list_idx_ff);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Decode of the held operation against the current length.
   always_comb begin
      op_status = STAT_OK;
      op_kind   = CELL_HOLD;
      op_pos    = '0;
      op_item   = '0;
      op_last   = 1'b1;
      new_cnt   = cnt_x;
      ins_pos   = pos_x;
      if (func_ff == FN_INS_FRONT) begin
         ins_pos = '0;
      end else if (func_ff == FN_INS_BACK) begin
         ins_pos = cnt_x;
      end
      case (func_ff)
         FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
            if (cnt_x == DEPTH_C) begin
               op_status = STAT_FULL;
            end else if (ins_pos > cnt_x) begin
               op_status = STAT_BADPOS;
            end else begin
               op_kind = CELL_INSERT;
               op_pos  = ins_pos;
               new_cnt = cnt_x + 1'b1;
            end
         end
         FN_DEL_FRONT: begin
            if (cnt_x == '0) begin
               op_status = STAT_EMPTY;
            end else begin
               op_kind = CELL_REMOVE;
               new_cnt = cnt_x - 1'b1;
            end
         end
         FN_DEL_BACK: begin
            if (cnt_x == '0) begin
               op_status = STAT_EMPTY;
            end else begin
               new_cnt = cnt_x - 1'b1;
            end
         end
         FN_DEL_AT: begin
            if (cnt_x == '0 && pos_x == '0) begin
               op_status = STAT_EMPTY;
            end else if (pos_x >= cnt_x) begin
               op_status = STAT_BADPOS;
            end else begin
               op_kind = CELL_REMOVE;
               op_pos  = pos_x;
               new_cnt = cnt_x - 1'b1;
            end
         end
         FN_DEL_VALUE: begin
            if (cnt_x == '0) begin
               op_status = STAT_EMPTY;
            end else if (any_hit) begin
               op_kind = CELL_REMOVE_HIT;
               new_cnt = cnt_x - 1'b1;
            end else begin
               op_status = STAT_NOTFOUND;
            end
         end
         FN_LIST: begin
            if (cnt_x == '0) begin
               op_status = STAT_EMPTY;
            end else begin
               op_kind = CELL_ROTATE;
               op_pos  = cnt_x - 1'b1;
               op_item = head_value;
               op_last = (idx_x == cnt_x - 1'b1);
            end
         end
         default: begin
            op_status = STAT_OK;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      operand_in    = operand_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      list_idx_in   = list_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_length_in = rsp_length_ff;
      req_tready    = 1'b0;
      ctrl          = '{kind: CELL_HOLD, pos: '0, count: cnt_x, operand: operand_ff};
      case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in    = func_type'(req_tdata[FUNC_W-1:0]);
               operand_in = req_tdata[FUNC_W +: VALUE_W];
               pos_in     = req_tdata[FUNC_W + VALUE_W +: POS_W];
               if (func_type'(req_tdata[FUNC_W-1:0]) == FN_DEL_VALUE) begin
                  state_in = SEQ_MATCH;
               end else begin
                  state_in = SEQ_EXEC;
               end
            end
         end
         SEQ_MATCH: begin
            ctrl.kind = CELL_COMPARE;
            state_in  = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            // Nothing moves until the result register can take the item.
            if (slot_free) begin
               ctrl.kind     = op_kind;
               ctrl.pos      = op_pos;
               count_in      = CW'(new_cnt);
               rsp_valid_in  = 1'b1;
               rsp_status_in = op_status;
               rsp_item_in   = op_item;
               rsp_last_in   = op_last;
               rsp_length_in = LEN_W'(new_cnt);
               if (op_last) begin
                  list_idx_in = '0;
                  state_in    = SEQ_IDLE;
               end else begin
                  list_idx_in = list_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         list_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         list_idx_ff  <= list_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      operand_ff    <= operand_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_length_ff, rsp_item_ff, rsp_status_ff};

endmodule

// ===== src/bounded_ordered_list_engine_unit.sv =====
// Top level of the bounded ordered list engine: sequencer and the chain of entry cells.
//
// The req channel carries one operation per item: insert at front, back or a
// position, delete at front, back, a position or by value, or list. The rsp
// channel returns one item per operation with its status and the length held
// afterwards; a listing returns one item per entry, front first, with tlast on
// the final one, or a single item with the empty status.
// Each entry lives in its own cell; an insert, delete or listing step shifts
// entries one place at most, and a listing step wraps the front entry to the end.
// Inserts and deletes by front, back or position go from accept to the execute
// step, which registers the result; delete by value has a compare step in all
// cells between the two. A listing runs one execute step per entry, one rotation
// step of the chain per result; a new operation waits until the last is done.
// The result register lets the next item be accepted while a result waits;
// a stalled receiver holds the engine in its execute step with no state change.
// Reset empties the list at once; entry storage is not cleared.
module bounded_ordered_list_engine_unit #(
   parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // func [2:0], operand_value [34:3], position [39:35]
   input  logic [bole_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // status [2:0], item_value [34:3], length [39:35]
   output logic [bole_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);
   import bole_pkg::*;

   cell_ctrl_type      ctrl;
   logic [VALUE_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]   match_vec;
   logic [DEPTH-1:0]   hit_vec;

   bole_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .head_value (cell_value[0]),
      .any_hit    (|match_vec),
      .ctrl       (ctrl)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] left_v;
      logic [VALUE_W-1:0] right_v;

      // A cell removes toward the front when a match lies at or before it.
      assign hit_vec[i] = |match_vec[i:0];

      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_inner_l
         assign left_v = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_inner_r
         assign right_v = cell_value[i+1];
      end

      bole_cell #(
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .hit_in      (hit_vec[i]),
         .value       (cell_value[i]),
         .match       (match_vec[i])
      );
   end

endmodule
